// ----- src/htrl_pkg.sv -----
// Shared types and constants for the HTTP request line tokenizer.
// Holds phase codes, token kinds, error codes and character constants.
// No dependencies.
package htrl_pkg;

  localparam int unsigned MAX_TOKEN_LEN = 10;
  localparam int unsigned LEN_W = 4;
  localparam int unsigned PREFIX_LEN = 5;
  localparam int unsigned PREFIX_W = 3;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL = 8'd127;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [LEN_W-1:0] TOKEN_LIMIT = LEN_W'(MAX_TOKEN_LEN);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_METHOD  = 5'b00010,
    PH_URL     = 5'b00100,
    PH_VERSION = 5'b01000,
    PH_CR      = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_METHOD  = 2'd1,
    KIND_URL     = 2'd2,
    KIND_VERSION = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_NOT_HTTP = 3'd1,
    ERR_METHOD   = 3'd2,
    ERR_URL      = 3'd3,
    ERR_VERSION  = 3'd4,
    ERR_CR       = 3'd5
  } err_t;

  typedef enum logic {
    REG_VERIFY_HTTP    = 1'b0,
    REG_CHECK_PROTOCOL = 1'b1
  } reg_index_t;

  function automatic logic [7:0] prefix_char(input logic [PREFIX_W-1:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h48;
      3'd1: ch = 8'h54;
      3'd2: ch = 8'h54;
      3'd3: ch = 8'h50;
      3'd4: ch = 8'h2f;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_text(input logic [7:0] c);
    return (c >= CH_SPACE) && (c != CH_DEL);
  endfunction

  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    return (v == LEN_MAX) ? LEN_MAX : v + LEN_W'(1);
  endfunction

endpackage

// ----- src/http_request_line_tokenizer.sv -----
// HTTP request line tokenizer: tags each byte with its token and flags line end.
// Bytes pass through the input register, then the result register.
// Throughput: one byte per cycle while out_ready holds, set by the single
// phase register update per byte. Synchronous active-high reset clears the
// parse phase, counters, configuration and both valid flags.
// Depends on htrl_pkg.
module http_request_line_tokenizer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            byte_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            byte_out,
  output logic [1:0]            token_kind,
  output logic                  line_done,
  output logic [2:0]            error_code,
  input  logic                  cfg_we,
  input  htrl_pkg::reg_index_t  cfg_index,
  input  logic                  cfg_data
);
  import htrl_pkg::*;

  logic                verify_http;
  logic                check_protocol;

  logic                in_held;
  logic [7:0]          in_byte;
  logic                advance;

  phase_t              phase, phase_next;
  logic [LEN_W-1:0]    method_length, method_length_next;
  logic                url_seen, url_seen_next;
  logic [LEN_W-1:0]    version_length, version_length_next;
  logic [PREFIX_W-1:0] prefix_matched, prefix_matched_next;
  logic                prefix_bad, prefix_bad_next;

  kind_t               kind;
  logic                done;
  err_t                err;
  err_t                finish_err;
  logic                prefix_ok;

  assign advance  = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || advance;

  assign prefix_ok  = (prefix_matched == PREFIX_W'(PREFIX_LEN)) && !prefix_bad;
  assign finish_err = (verify_http && check_protocol && !prefix_ok) ? ERR_NOT_HTTP : ERR_OK;

  always_comb begin
    phase_next          = phase;
    method_length_next  = method_length;
    url_seen_next       = url_seen;
    version_length_next = version_length;
    prefix_matched_next = prefix_matched;
    prefix_bad_next     = prefix_bad;
    kind = KIND_NONE;
    done = 1'b0;
    err  = ERR_OK;
    case (phase)
      PH_METHOD: begin
        if (in_byte == CH_SPACE) begin
          if (method_length != '0) phase_next = PH_URL;
        end else if (is_text(in_byte)) begin
          method_length_next = sat_inc(method_length);
          if (verify_http && (method_length_next > TOKEN_LIMIT)) err = ERR_NOT_HTTP;
          else kind = KIND_METHOD;
        end else begin
          err = ERR_METHOD;
        end
      end
      PH_URL: begin
        if (in_byte == CH_SPACE) begin
          if (url_seen) phase_next = PH_VERSION;
        end else if (is_text(in_byte)) begin
          url_seen_next = 1'b1;
          kind = KIND_URL;
        end else begin
          err = ERR_URL;
        end
      end
      PH_VERSION: begin
        if (in_byte == CH_CR) begin
          phase_next = PH_CR;
        end else if (in_byte == CH_LF) begin
          err  = finish_err;
          done = (finish_err == ERR_OK);
          phase_next          = PH_IDLE;
          method_length_next  = '0;
          url_seen_next       = 1'b0;
          version_length_next = '0;
          prefix_matched_next = '0;
          prefix_bad_next     = 1'b0;
        end else if (in_byte == CH_SPACE) begin
          phase_next = phase;
        end else if (is_text(in_byte)) begin
          if (version_length < LEN_W'(PREFIX_LEN)) begin
            if (!prefix_bad && (in_byte == prefix_char(version_length[PREFIX_W-1:0])))
              prefix_matched_next = prefix_matched + PREFIX_W'(1);
            else
              prefix_bad_next = 1'b1;
          end
          version_length_next = sat_inc(version_length);
          if (verify_http && (version_length_next > TOKEN_LIMIT)) err = ERR_NOT_HTTP;
          else kind = KIND_VERSION;
        end else begin
          err = ERR_VERSION;
        end
      end
      PH_CR: begin
        if (in_byte == CH_LF) begin
          err  = finish_err;
          done = (finish_err == ERR_OK);
          phase_next          = PH_IDLE;
          method_length_next  = '0;
          url_seen_next       = 1'b0;
          version_length_next = '0;
          prefix_matched_next = '0;
          prefix_bad_next     = 1'b0;
        end else begin
          err = ERR_CR;
        end
      end
      default: begin
        phase_next          = PH_IDLE;
        method_length_next  = '0;
        url_seen_next       = 1'b0;
        version_length_next = '0;
        prefix_matched_next = '0;
        prefix_bad_next     = 1'b0;
        if (is_text(in_byte) && (in_byte != CH_SPACE)) begin
          method_length_next = LEN_W'(1);
          phase_next         = PH_METHOD;
          kind               = KIND_METHOD;
        end
      end
    endcase
    if (err != ERR_OK) begin
      phase_next          = PH_IDLE;
      method_length_next  = '0;
      url_seen_next       = 1'b0;
      version_length_next = '0;
      prefix_matched_next = '0;
      prefix_bad_next     = 1'b0;
      kind = KIND_NONE;
      done = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verify_http    <= 1'b0;
      check_protocol <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERIFY_HTTP:    verify_http    <= cfg_data;
        REG_CHECK_PROTOCOL: check_protocol <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
    if (in_ready && in_valid) in_byte <= byte_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      method_length  <= '0;
      url_seen       <= 1'b0;
      version_length <= '0;
      prefix_matched <= '0;
      prefix_bad     <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      method_length  <= method_length_next;
      url_seen       <= url_seen_next;
      version_length <= version_length_next;
      prefix_matched <= prefix_matched_next;
      prefix_bad     <= prefix_bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      byte_out   <= in_byte;
      token_kind <= kind;
      line_done  <= done;
      error_code <= err;
    end
  end

endmodule

// ----- sim/tokenizer_tag_checker.sv -----
// Checker for the HTTP request line tokenizer: predicts the tag of every
// accepted request byte and compares it with the results that come out.
// Depends on htrl_pkg.
module tokenizer_tag_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           byte_in,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [7:0]           byte_out,
  input  logic [1:0]           token_kind,
  input  logic                 line_done,
  input  logic [2:0]           error_code,
  input  logic                 cfg_we,
  input  htrl_pkg::reg_index_t cfg_index,
  input  logic                 cfg_data,
  output int                   mismatches,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import htrl_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       done;
    err_t       err;
  } tag_t;

  localparam logic [39:0] PROTO_WORD = "HTTP/";

  tag_t pending_tags[$];
  int   err_count = 0;

  logic                verify_on;
  logic                proto_on;
  phase_t              phase;
  logic [LEN_W-1:0]    meth_len;
  logic                url_hit;
  logic [LEN_W-1:0]    ver_len;
  logic [PREFIX_W-1:0] pfx_hits;
  logic                pfx_broken;

  function automatic logic printable_byte(input logic [7:0] c);
    return c >= CH_SPACE && c != CH_DEL;
  endfunction

  function automatic logic [LEN_W-1:0] bump_count(input logic [LEN_W-1:0] v);
    return (v == LEN_MAX) ? v : v + 1'b1;
  endfunction

  function automatic void clear_parse();
    phase = PH_IDLE;
    meth_len = '0;
    url_hit = 1'b0;
    ver_len = '0;
    pfx_hits = '0;
    pfx_broken = 1'b0;
  endfunction

  function automatic err_t close_line();
    err_t e;
    e = ERR_OK;
    if (verify_on && proto_on && !(pfx_hits == PREFIX_LEN && !pfx_broken)) e = ERR_NOT_HTTP;
    clear_parse();
    return e;
  endfunction

  function automatic tag_t tag_byte(input logic [7:0] c);
    tag_t t;
    t.data = c;
    t.kind = KIND_NONE;
    t.done = 1'b0;
    t.err = ERR_OK;
    case (phase)
      PH_METHOD: begin
        if (c == CH_SPACE) begin
          if (meth_len != 0) phase = PH_URL;
        end else if (printable_byte(c)) begin
          meth_len = bump_count(meth_len);
          if (verify_on && meth_len > MAX_TOKEN_LEN) t.err = ERR_NOT_HTTP;
          else t.kind = KIND_METHOD;
        end else begin
          t.err = ERR_METHOD;
        end
      end
      PH_URL: begin
        if (c == CH_SPACE) begin
          if (url_hit) phase = PH_VERSION;
        end else if (printable_byte(c)) begin
          url_hit = 1'b1;
          t.kind = KIND_URL;
        end else begin
          t.err = ERR_URL;
        end
      end
      PH_VERSION: begin
        if (c == CH_CR) begin
          phase = PH_CR;
        end else if (c == CH_LF) begin
          t.err = close_line();
          t.done = (t.err == ERR_OK);
        end else if (c == CH_SPACE) begin
        end else if (printable_byte(c)) begin
          if (ver_len < PREFIX_LEN) begin
            if (!pfx_broken && c == PROTO_WORD[39 - 8 * ver_len -: 8])
              pfx_hits = pfx_hits + 1'b1;
            else pfx_broken = 1'b1;
          end
          ver_len = bump_count(ver_len);
          if (verify_on && ver_len > MAX_TOKEN_LEN) t.err = ERR_NOT_HTTP;
          else t.kind = KIND_VERSION;
        end else begin
          t.err = ERR_VERSION;
        end
      end
      PH_CR: begin
        if (c == CH_LF) begin
          t.err = close_line();
          t.done = (t.err == ERR_OK);
        end else begin
          t.err = ERR_CR;
        end
      end
      default: begin
        clear_parse();
        if (printable_byte(c) && c != CH_SPACE) begin
          meth_len = LEN_W'(1);
          phase = PH_METHOD;
          t.kind = KIND_METHOD;
        end
      end
    endcase
    if (t.err != ERR_OK) begin
      clear_parse();
      t.kind = KIND_NONE;
      t.done = 1'b0;
    end
    return t;
  endfunction

  always @(posedge clk) begin
    tag_t got;
    tag_t want;
    if (rst) begin
      verify_on = 1'b0;
      proto_on = 1'b0;
      clear_parse();
      pending_tags.delete();
      err_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_VERIFY_HTTP: verify_on = cfg_data;
          REG_CHECK_PROTOCOL: proto_on = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got.data = byte_out;
        got.kind = kind_t'(token_kind);
        got.done = line_done;
        got.err = err_t'(error_code);
        if (pending_tags.size() == 0) begin
          $display("%0t: unexpected result byte %02h kind %0d done %0b err %0d", $time,
                   got.data, got.kind, got.done, got.err);
          err_count++;
        end else begin
          want = pending_tags.pop_front();
          if (got !== want) begin
            $display("%0t: expected byte/kind/done/err %02h/%0d/%0b/%0d, got %02h/%0d/%0b/%0d",
                     $time, want.data, want.kind, want.done, want.err,
                     got.data, got.kind, got.done, got.err);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) pending_tags.push_back(tag_byte(byte_in));
    end
    outstanding <= pending_tags.size();
    mismatches <= err_count;
  end

endmodule

// ----- sim/http_request_line_tokenizer_tb.sv -----
// Testbench top for the HTTP request line tokenizer: drives request bytes
// and register settings, and gives the verdict from tokenizer_tag_checker.
// Depends on htrl_pkg, http_request_line_tokenizer and tokenizer_tag_checker.
module http_request_line_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import htrl_pkg::*;

  localparam logic [39:0] PROTO_WORD = "HTTP/";
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 300;
  localparam bit PHASE_VERIFY [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
  localparam bit PHASE_PROTO [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
  localparam logic [7:0] OPENING_BYTES [27] = '{
    8'h00, CH_SPACE, 8'hFF, CH_DEL,
    "A", CH_SPACE, "/", CH_SPACE, "H", "T", "T", "P", "/", CH_CR, CH_LF,
    "B", CH_SPACE, "u", CH_SPACE, CH_LF,
    "x", CH_SPACE, "y", CH_SPACE, "z", CH_CR, "q"
  };

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] byte_in = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] byte_out;
  logic [1:0] token_kind;
  logic       line_done;
  logic [2:0] error_code;
  logic       cfg_we = 1'b0;
  reg_index_t cfg_index = REG_VERIFY_HTTP;
  logic       cfg_data = 1'b0;

  int mismatches;
  int outstanding;
  int sent_count = 0;
  int rx_hold = 0;
  bit tx_free = 1'b0;
  bit rx_free = 1'b0;

  http_request_line_tokenizer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .byte_in(byte_in),
    .out_valid(out_valid), .out_ready(out_ready), .byte_out(byte_out),
    .token_kind(token_kind), .line_done(line_done), .error_code(error_code),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tokenizer_tag_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .byte_in(byte_in),
    .out_valid(out_valid), .out_ready(out_ready), .byte_out(byte_out),
    .token_kind(token_kind), .line_done(line_done), .error_code(error_code),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(33, 126));
  endfunction

  function automatic logic [7:0] ctrl_byte();
    if ($urandom_range(0, 4) == 0) return CH_DEL;
    return 8'($urandom_range(0, 31));
  endfunction

  // stall the result side: mostly ready, short and occasional long holds
  always @(posedge clk) begin
    if (rx_free) begin
      out_ready <= 1'b1;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if ($urandom_range(0, 2) != 0) begin
      out_ready <= 1'b1;
      rx_hold <= $urandom_range(0, 20);
    end else begin
      out_ready <= 1'b0;
      rx_hold <= idle_len();
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_free ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_spaces();
    repeat ($urandom_range(1, 3)) send_byte(CH_SPACE);
  endtask

  task automatic send_text(input int n);
    repeat (n) send_byte(text_byte());
  endtask

  task automatic send_version();
    int v;
    int k;
    v = $urandom_range(0, 19);
    if (v < 11) begin
      for (k = 0; k < 5; k++) send_byte(PROTO_WORD[39 - 8 * k -: 8]);
      repeat ($urandom_range(0, 5))
        send_byte(($urandom_range(0, 5) == 0) ? CH_SPACE : text_byte());
    end else if (v < 13) begin
      v = $urandom_range(0, 4);
      for (k = 0; k < 5; k++) send_byte((k == v) ? text_byte() : PROTO_WORD[39 - 8 * k -: 8]);
    end else if (v < 16) begin
      send_text($urandom_range(1, 8));
    end else if (v < 18) begin
      v = $urandom_range(0, 4);
      for (k = 0; k < v; k++) send_byte(PROTO_WORD[39 - 8 * k -: 8]);
    end else begin
      for (k = 0; k < 5; k++) send_byte(PROTO_WORD[39 - 8 * k -: 8]);
      send_text($urandom_range(6, 9));
    end
  endtask

  // one request line; a broken one stops at a random point with a control byte, or with a non-LF byte after CR
  task automatic send_line(input bit broken);
    int cut;
    logic [7:0] b;
    cut = broken ? $urandom_range(0, 3) : 4;
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_byte($urandom_range(0, 1) ? CH_SPACE : ctrl_byte());
    send_text(($urandom_range(0, 6) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 8));
    if (cut == 0) begin
      send_byte(ctrl_byte());
      return;
    end
    send_spaces();
    send_text($urandom_range(1, 8));
    if (cut == 1) begin
      send_byte(ctrl_byte());
      return;
    end
    send_spaces();
    send_version();
    if (cut == 2) begin
      send_byte(ctrl_byte());
    end else if (cut == 3) begin
      send_byte(CH_CR);
      b = 8'($urandom_range(0, 255));
      send_byte((b == CH_LF) ? CH_CR : b);
    end else begin
      if ($urandom_range(0, 2) != 0) send_byte(CH_CR);
      send_byte(CH_LF);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic verify, input logic proto);
    cfg_we <= 1'b1;
    cfg_index <= REG_VERIFY_HTTP;
    cfg_data <= verify;
    @(posedge clk);
    cfg_index <= REG_CHECK_PROTOCOL;
    cfg_data <= proto;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int p;
    int target;
    int pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);
    for (p = 0; p < PHASES; p++) begin
      settle();
      configure(PHASE_VERIFY[p], PHASE_PROTO[p]);
      tx_free <= (p == 3);
      rx_free <= (p == 3);
      target = sent_count + PHASE_ITEMS;
      while (sent_count < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) send_line(1'b0);
        else if (pick < 85) send_line(1'b1);
        else send_noise();
      end
    end
    settle();
    $display("Sent %0d request bytes under %0d register settings: good, broken and noise.",
             sent_count, PHASES + 1);
    $display("Checker reported %0d mismatches with %0d results still pending.",
             mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timed out with %0d results pending.", outstanding);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
src/htrl_pkg.sv
src/http_request_line_tokenizer.sv
sim/tokenizer_tag_checker.sv
sim/http_request_line_tokenizer_tb.sv
